// ===== hw/rtl/utt_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; utt_decode and the top level import this package.
`default_nettype none

package utt_pkg;

   // UTF-8 lead byte ranges
   localparam logic [7:0] ContMin     = 8'h80;
   localparam logic [7:0] Lead2Min    = 8'hC0;
   localparam logic [7:0] Lead3Min    = 8'hE0;
   localparam logic [7:0] Lead4Min    = 8'hF0;
   localparam logic [7:0] LeadBadMin  = 8'hF5;

   // scalar value limits
   localparam int unsigned ScalarWidth = 21;
   localparam logic [ScalarWidth-1:0] Min2Byte    = 21'h00080;
   localparam logic [ScalarWidth-1:0] Min3Byte    = 21'h00800;
   localparam logic [ScalarWidth-1:0] SupplBase   = 21'h10000;
   localparam logic [ScalarWidth-1:0] ScalarMax   = 21'h10FFFF;
   localparam logic [ScalarWidth-1:0] SurrFirst   = 21'h0D800;
   localparam logic [ScalarWidth-1:0] SurrLast    = 21'h0DFFF;

   // UTF-16 surrogate offsets
   localparam logic [15:0] HighSurrBase = 16'hD800;
   localparam logic [15:0] LowSurrBase  = 16'hDC00;
   localparam logic [9:0]  SurrLowMask  = 10'h3FF;

   // result status codes
   localparam logic StatusOk    = 1'b0;
   localparam logic StatusError = 1'b1;

   // result queue
   localparam int unsigned FifoDepth  = 4;
   localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
   localparam int unsigned FifoCountW = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic [15:0] code_unit;
      logic        status;
      logic        run_last;
      logic        text_done;
   } utt_result_type;

   // results produced by one byte: zero, one or two
   typedef struct packed {
      logic [1:0]     count;
      utt_result_type first;
      utt_result_type second;
   } utt_push_type;

endpackage

`default_nettype wire

// ===== hw/rtl/utt_if.sv =====
// Valid/ready channel interfaces for the transcoder byte input and result output.
// No dependencies.
`default_nettype none

interface utt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        status;
   logic        run_last;
   logic        text_done;

   modport source (output valid, output code_unit, output status, output run_last,
                   output text_done, input ready);
   modport sink   (input valid, input code_unit, input status, input run_last,
                   input text_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utt_decode.sv =====
// Sequence state and per-byte decode of the UTF-8 to UTF-16 transcoder.
// Depends on utt_pkg.
`default_nettype none

module utt_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          data_byte,
   input  wire logic                end_of_text,
   output utt_pkg::utt_push_type    push
);
   import utt_pkg::*;

   logic [1:0]             remain_ff, remain_in;
   logic [2:0]             len_ff, len_in;
   logic [ScalarWidth-1:0] partial_ff, partial_in;
   logic                   hold_ff, hold_in;

   logic [ScalarWidth-1:0] shifted;
   logic [ScalarWidth-1:0] value;
   logic [ScalarWidth-1:0] suppl;
   logic [1:0]             remain_dec;
   logic                   fire_err;
   logic                   fire_val;
   logic                   bad;

   always_comb begin
      shifted    = {partial_ff[ScalarWidth-7:0], data_byte[5:0]};
      remain_dec = remain_ff - 2'd1;
      suppl      = shifted - SupplBase;
      remain_in  = remain_ff;
      len_in     = len_ff;
      partial_in = partial_ff;
      hold_in    = hold_ff;
      fire_err   = 1'b0;
      fire_val   = 1'b0;
      bad        = 1'b0;
      value      = {{(ScalarWidth-8){1'b0}}, data_byte};
      push       = '0;

      if (hold_ff) begin
         // drop bytes until the end of text
         if (end_of_text) begin
            hold_in    = 1'b0;
            remain_in  = '0;
            len_in     = '0;
            partial_in = '0;
         end
      end else if (remain_ff == 2'd0) begin
         if (data_byte < ContMin) begin
            fire_val = 1'b1;
         end else if (data_byte < Lead2Min || data_byte >= LeadBadMin) begin
            fire_err = 1'b1;
         end else begin
            if (data_byte < Lead3Min) begin
               len_in     = 3'd2;
               remain_in  = 2'd1;
               partial_in = {{(ScalarWidth-5){1'b0}}, data_byte[4:0]};
            end else if (data_byte < Lead4Min) begin
               len_in     = 3'd3;
               remain_in  = 2'd2;
               partial_in = {{(ScalarWidth-4){1'b0}}, data_byte[3:0]};
            end else begin
               len_in     = 3'd4;
               remain_in  = 2'd3;
               partial_in = {{(ScalarWidth-3){1'b0}}, data_byte[2:0]};
            end
            fire_err = end_of_text;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         fire_err = 1'b1;
      end else begin
         partial_in = shifted;
         remain_in  = remain_dec;
         if (remain_dec != 2'd0) begin
            fire_err = end_of_text;
         end else begin
            bad = (len_ff == 3'd2 && shifted < Min2Byte) ||
                  (len_ff == 3'd3 && shifted < Min3Byte) ||
                  (len_ff == 3'd4 && (shifted < SupplBase || shifted > ScalarMax)) ||
                  (shifted >= SurrFirst && shifted <= SurrLast);
            fire_err = bad;
            fire_val = !bad;
            value    = shifted;
            suppl    = shifted - SupplBase;
         end
      end

      if (fire_err) begin
         remain_in  = '0;
         len_in     = '0;
         partial_in = '0;
         hold_in    = !end_of_text;
         push.count = 2'd1;
         push.first = '{code_unit: 16'h0000, status: StatusError, run_last: 1'b1,
                        text_done: end_of_text};
      end else if (fire_val) begin
         remain_in  = '0;
         len_in     = '0;
         partial_in = '0;
         if (value < SupplBase) begin
            push.count = 2'd1;
            push.first = '{code_unit: value[15:0], status: StatusOk, run_last: 1'b1,
                           text_done: end_of_text};
         end else begin
            // split into a high and low surrogate
            push.count  = 2'd2;
            push.first  = '{code_unit: HighSurrBase + {6'b0, suppl[19:10]},
                            status: StatusOk, run_last: 1'b0, text_done: end_of_text};
            push.second = '{code_unit: LowSurrBase + {6'b0, suppl[9:0] & SurrLowMask},
                            status: StatusOk, run_last: 1'b1, text_done: end_of_text};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= '0;
         len_ff     <= '0;
         partial_ff <= '0;
         hold_ff    <= 1'b0;
      end else if (step) begin
         remain_ff  <= remain_in;
         len_ff     <= len_in;
         partial_ff <= partial_in;
         hold_ff    <= hold_in;
      end
   end

`ifndef SYNTHESIS
   a_eot_restores_reset: assert property (@(posedge clock) disable iff (reset)
      step && end_of_text |=> remain_ff == 2'd0 && len_ff == 3'd0 && !hold_ff)
      else $error("end of text did not return decoder to idle");

   a_hold_has_no_sequence: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> remain_ff == 2'd0 && len_ff == 3'd0)
      else $error("sequence in progress while dropping bytes");

   a_pair_is_surrogates: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.code_unit[15:10] == 6'b110110 &&
                             push.second.code_unit[15:10] == 6'b110111 &&
                             push.first.status == StatusOk && !push.first.run_last)
      else $error("malformed surrogate pair");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, result queue.
// Depends on utt_pkg, utt_if and utt_decode.
`default_nettype none

// The transcoder takes one UTF-8 byte per beat on req_if, with end_of_text
// marking the final byte of a text, and returns UTF-16 code units on rsp_if.
// A finished scalar below 0x10000 gives one result; a larger one gives a high
// and a low surrogate on two consecutive beats, run_last set on the second.
// Any bad encoding (stray continuation or bad lead byte, missing continuation,
// overlong form, surrogate value, value above 0x10FFFF, or text cut off
// inside a sequence) gives one result with status 1 and code unit zero; the
// following bytes of that text are dropped without results, and the end of
// text returns the block to its reset state. Throughput is one byte per
// clock: the byte is registered on acceptance and decoded from that register
// into a four-entry result queue; a byte moves on only while the queue holds
// two or fewer results, so the rate drops below one byte per cycle only when
// the output side stalls. The first result of a byte is offered on rsp_if once
// it has passed the input register and been written into the result queue.
module utf8_to_utf16_transcoder (
   input  wire logic  clock,
   input  wire logic  reset,
   utt_req_if.sink    req_if,
   utt_rsp_if.source  rsp_if
);
   import utt_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // result queue
   utt_result_type        fifo_ff [FifoDepth];
   logic [FifoPtrW-1:0]   head_ff, head_in;
   logic [FifoPtrW-1:0]   tail_ff, tail_in;
   logic [FifoCountW-1:0] count_ff, count_in;

   utt_push_type          push;
   logic                  req_take;
   logic                  rsp_take;
   logic                  room;
   logic                  advance;
   logic [1:0]            push_n;
   logic [FifoPtrW-1:0]   tail_next;
   utt_result_type        head_entry;

   // decode the held byte; state advances only when its results fit
   utt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .push        (push)
   );

   always_comb begin
      room      = count_ff <= FifoCountW'(FifoDepth - 2);
      advance   = in_valid_ff && room;
      req_take  = req_if.valid && req_if.ready;
      rsp_take  = rsp_if.valid && rsp_if.ready;
      push_n    = advance ? push.count : 2'd0;
      tail_next = tail_ff + FifoPtrW'(1);

      // hold the byte until the queue has room for a surrogate pair
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

      head_in  = rsp_take ? head_ff + FifoPtrW'(1) : head_ff;
      tail_in  = tail_ff + FifoPtrW'(push_n);
      count_in = count_ff + FifoCountW'(push_n) - FifoCountW'(rsp_take);

      head_entry = fifo_ff[head_ff];
   end

   assign req_if.ready     = !in_valid_ff || advance;
   assign rsp_if.valid     = count_ff != '0;
   assign rsp_if.code_unit = head_entry.code_unit;
   assign rsp_if.status    = head_entry.status;
   assign rsp_if.run_last  = head_entry.run_last;
   assign rsp_if.text_done = head_entry.text_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.data_byte;
         in_eot_ff  <= req_if.end_of_text;
      end
      if (push_n != 2'd0) begin
         fifo_ff[tail_ff] <= push.first;
      end
      if (push_n == 2'd2) begin
         fifo_ff[tail_next] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FifoCountW'(FifoDepth))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      advance |-> ({1'b0, count_ff} + (FifoCountW + 1)'(push.count)) <=
                  (FifoCountW + 1)'(FifoDepth))
      else $error("result queue overflow");

   a_error_unit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == StatusError |->
         rsp_if.code_unit == 16'h0000 && rsp_if.run_last)
      else $error("error result carries data");
`endif

endmodule

`default_nettype wire
